// ----- sv/fpbc_pkg.sv -----
// Shared types, constants and helpers for the frustum point/box cull core.
`timescale 1ns / 1ps

package fpbc_pkg;

	localparam int COEF_W = 16;
	localparam int COORD_IN_W = 16;
	localparam int COORD_W = 17;
	localparam int RADIUS_W = 15;
	localparam int NUM_PTS = 9;
	localparam int NUM_PLANE_REGS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 64;
	localparam int PROD_W = COEF_W + COORD_W;
	localparam int DOT_W = PROD_W + 2;
	localparam int ONE_SHIFT = 8;

	typedef enum logic [1:0] {
		ACT_POINT  = 2'd0,
		ACT_BOX    = 2'd1,
		ACT_SPHERE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	function automatic logic signed [COORD_W-1:0] half_sum(
		input logic signed [COORD_W-1:0] lo,
		input logic signed [COORD_W-1:0] hi
	);
		logic signed [COORD_W:0] s;
		s = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
		return s[COORD_W:1];
	endfunction

endpackage

// ----- sv/frustum_point_box_cull_core.sv -----
// Top level of the frustum point/box cull core: plane registers, pipeline control.
//
// Usage: load the plane registers through cfg_we/cfg_index/cfg_wdata (index 0..5 =
// near, far, left, right, top, bottom; a,b,c,d signed Q1.14 in 16-bit fields, a
// lowest). Writes take effect at the clock edge; indices past the last plane are
// ignored. Write planes only while no word is in flight.
// A word is taken at each rising edge with start high and busy low. busy is always
// low: the core takes one word every cycle with no gaps.
// action selects point, box (min/max), sphere (center/radius) in Q8.8, or none (never visible).
// done pulses for one cycle once the word has passed the input, test point and product
// registers, with visible valid in that cycle; results come out in order, one per word.
// Pipeline: input register, test point formation (center plus eight corners),
// per-plane product register, then dot-product signs reduced into the result
// register. Nine point lanes run in parallel, each with 3*PLANE_COUNT multipliers.
// The receiver cannot stall; done is a bare strobe.
// Reset clears all plane registers to zero (every point, box and sphere visible) and
// empties the pipeline; no word in flight at reset produces a result.
`timescale 1ns / 1ps

module frustum_point_box_cull_core #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             action,
	input  logic signed [15:0]                     first_x,
	input  logic signed [15:0]                     first_y,
	input  logic signed [15:0]                     first_z,
	input  logic signed [15:0]                     second_x,
	input  logic signed [15:0]                     second_y,
	input  logic signed [15:0]                     second_z,
	input  logic [14:0]                            sphere_radius,
	output logic                                   done,
	output logic                                   visible,
	input  logic                                   cfg_we,
	input  logic [fpbc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fpbc_pkg::CFG_W-1:0]             cfg_wdata
);

	fpbc_pkg::plane_t [PLANE_COUNT-1:0] plane_q;

	logic valid_s1, valid_s2, valid_s3, done_q, visible_q;
	fpbc_pkg::action_t action_s1;
	logic signed [fpbc_pkg::COORD_IN_W-1:0] fx_s1, fy_s1, fz_s1, sx_s1, sy_s1, sz_s1;
	logic [fpbc_pkg::RADIUS_W-1:0] radius_s1;
	fpbc_pkg::point_t [fpbc_pkg::NUM_PTS-1:0] pts_s2;
	logic [fpbc_pkg::NUM_PTS-1:0] mask_s2, mask_s3, inside_s3;
	logic accept;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign done    = done_q;
	assign visible = visible_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_we && (32'(cfg_index) < PLANE_COUNT)) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				if (32'(cfg_index) == p) begin
					plane_q[p] <= fpbc_pkg::plane_t'(cfg_wdata);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= fpbc_pkg::action_t'(action);
			fx_s1     <= first_x;
			fy_s1     <= first_y;
			fz_s1     <= first_z;
			sx_s1     <= second_x;
			sy_s1     <= second_y;
			sz_s1     <= second_z;
			radius_s1 <= sphere_radius;
		end
		mask_s3   <= mask_s2;
		visible_q <= |(mask_s3 & inside_s3);
	end

	fpbc_point_gen u_point_gen (
		.clk         (clk),
		.action_s1   (action_s1),
		.first_x_s1  (fx_s1),
		.first_y_s1  (fy_s1),
		.first_z_s1  (fz_s1),
		.second_x_s1 (sx_s1),
		.second_y_s1 (sy_s1),
		.second_z_s1 (sz_s1),
		.radius_s1   (radius_s1),
		.pts_s2      (pts_s2),
		.mask_s2     (mask_s2)
	);

	for (genvar g = 0; g < fpbc_pkg::NUM_PTS; g++) begin : g_lane
		fpbc_plane_lane #(
			.PLANE_COUNT (PLANE_COUNT)
		) u_lane (
			.clk       (clk),
			.pt_s2     (pts_s2[g]),
			.planes    (plane_q),
			.inside_s3 (inside_s3[g])
		);
	end

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("done missing after accepted word");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("done without accepted word");

	a_empty_mask_invisible: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (mask_s3 == '0)) |=> !visible)
		else $error("visible set with no tested point");

endmodule

// ----- sv/fpbc_point_gen.sv -----
// Test point formation: the point itself, or box or sphere bounds to center plus eight corners, registered.
`timescale 1ns / 1ps

module fpbc_point_gen (
	input  logic                                            clk,
	input  fpbc_pkg::action_t                               action_s1,
	input  logic signed [fpbc_pkg::COORD_IN_W-1:0]          first_x_s1,
	input  logic signed [fpbc_pkg::COORD_IN_W-1:0]          first_y_s1,
	input  logic signed [fpbc_pkg::COORD_IN_W-1:0]          first_z_s1,
	input  logic signed [fpbc_pkg::COORD_IN_W-1:0]          second_x_s1,
	input  logic signed [fpbc_pkg::COORD_IN_W-1:0]          second_y_s1,
	input  logic signed [fpbc_pkg::COORD_IN_W-1:0]          second_z_s1,
	input  logic [fpbc_pkg::RADIUS_W-1:0]                   radius_s1,
	output fpbc_pkg::point_t [fpbc_pkg::NUM_PTS-1:0]        pts_s2,
	output logic [fpbc_pkg::NUM_PTS-1:0]                    mask_s2
);

	fpbc_pkg::point_t lo, hi, ctr;
	fpbc_pkg::point_t [fpbc_pkg::NUM_PTS-1:0] pts;
	logic [fpbc_pkg::NUM_PTS-1:0] mask;
	logic signed [fpbc_pkg::COORD_W-1:0] fx, fy, fz, sx, sy, sz, rad;

	always_comb begin
		fx = {first_x_s1[fpbc_pkg::COORD_IN_W-1], first_x_s1};
		fy = {first_y_s1[fpbc_pkg::COORD_IN_W-1], first_y_s1};
		fz = {first_z_s1[fpbc_pkg::COORD_IN_W-1], first_z_s1};
		sx = {second_x_s1[fpbc_pkg::COORD_IN_W-1], second_x_s1};
		sy = {second_y_s1[fpbc_pkg::COORD_IN_W-1], second_y_s1};
		sz = {second_z_s1[fpbc_pkg::COORD_IN_W-1], second_z_s1};
		rad = {{(fpbc_pkg::COORD_W - fpbc_pkg::RADIUS_W){1'b0}}, radius_s1};
		if (action_s1 == fpbc_pkg::ACT_SPHERE) begin
			lo = '{x: fx - rad, y: fy - rad, z: fz - rad};
			hi = '{x: fx + rad, y: fy + rad, z: fz + rad};
		end else begin
			lo = '{x: fx, y: fy, z: fz};
			hi = '{x: sx, y: sy, z: sz};
		end
		ctr.x = fpbc_pkg::half_sum(lo.x, hi.x);
		ctr.y = fpbc_pkg::half_sum(lo.y, hi.y);
		ctr.z = fpbc_pkg::half_sum(lo.z, hi.z);
		// slot 0: the point itself or the box center; slots 1..8: corners
		if (action_s1 == fpbc_pkg::ACT_POINT) begin
			pts[0] = lo;
		end else begin
			pts[0] = ctr;
		end
		for (int c = 0; c < 8; c++) begin
			pts[c+1].x = c[0] ? hi.x : lo.x;
			pts[c+1].y = c[1] ? hi.y : lo.y;
			pts[c+1].z = c[2] ? hi.z : lo.z;
		end
		case (action_s1)
			fpbc_pkg::ACT_POINT:  mask = {{(fpbc_pkg::NUM_PTS-1){1'b0}}, 1'b1};
			fpbc_pkg::ACT_BOX:    mask = '1;
			fpbc_pkg::ACT_SPHERE: mask = '1;
			default:              mask = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		pts_s2  <= pts;
		mask_s2 <= mask;
	end

endmodule

// ----- sv/fpbc_plane_lane.sv -----
// One test point against all planes: registered products, then sign of each dot product.
`timescale 1ns / 1ps

module fpbc_plane_lane #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                                  clk,
	input  fpbc_pkg::point_t                      pt_s2,
	input  fpbc_pkg::plane_t [PLANE_COUNT-1:0]    planes,
	output logic                                  inside_s3
);

	logic signed [fpbc_pkg::PROD_W-1:0] pa_s3 [PLANE_COUNT];
	logic signed [fpbc_pkg::PROD_W-1:0] pb_s3 [PLANE_COUNT];
	logic signed [fpbc_pkg::PROD_W-1:0] pc_s3 [PLANE_COUNT];
	logic signed [fpbc_pkg::COEF_W-1:0] d_s3  [PLANE_COUNT];
	logic signed [fpbc_pkg::DOT_W-1:0]  dot   [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]             ok;

	always_ff @(posedge clk) begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			pa_s3[p] <= planes[p].a * pt_s2.x;
			pb_s3[p] <= planes[p].b * pt_s2.y;
			pc_s3[p] <= planes[p].c * pt_s2.z;
			d_s3[p]  <= planes[p].d;
		end
	end

	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			// d times 1.0 in Q8.8
			dot[p] = fpbc_pkg::DOT_W'(pa_s3[p]) + fpbc_pkg::DOT_W'(pb_s3[p])
				+ fpbc_pkg::DOT_W'(pc_s3[p])
				+ (fpbc_pkg::DOT_W'(d_s3[p]) <<< fpbc_pkg::ONE_SHIFT);
			ok[p] = ~dot[p][fpbc_pkg::DOT_W-1];
		end
		inside_s3 = &ok;
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the frustum point/box cull core: directed and random words.
`timescale 1ns / 1ps

module tb_top;

	localparam int PLANES_TESTED = 6;
	localparam int ITEMS_PER_SET = 123;
	localparam int SET_COUNT = 10;
	localparam int HOLD_OFF = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;

	typedef struct {
		fpbc_pkg::action_t act;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] sz;
		logic [14:0] rad;
	} cull_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] action;
	logic signed [15:0] first_x;
	logic signed [15:0] first_y;
	logic signed [15:0] first_z;
	logic signed [15:0] second_x;
	logic signed [15:0] second_y;
	logic signed [15:0] second_z;
	logic [14:0] sphere_radius;
	logic done;
	logic visible;
	logic cfg_we;
	logic [fpbc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fpbc_pkg::CFG_W-1:0] cfg_wdata;

	cull_word_t cur_word;
	fpbc_pkg::plane_t plane_model [fpbc_pkg::NUM_PLANE_REGS];
	logic [fpbc_pkg::CFG_W-1:0] plane_set [fpbc_pkg::NUM_PLANE_REGS];
	bit visible_q [$];
	bit want_vis;
	int accept_count = 0;
	int errors = 0;
	int burst_left;
	int cycle_count = 0;

	assign action = cur_word.act;
	assign first_x = cur_word.fx;
	assign first_y = cur_word.fy;
	assign first_z = cur_word.fz;
	assign second_x = cur_word.sx;
	assign second_y = cur_word.sy;
	assign second_z = cur_word.sz;
	assign sphere_radius = cur_word.rad;

	frustum_point_box_cull_core #(
		.PLANE_COUNT(PLANES_TESTED)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.first_x(first_x),
		.first_y(first_y),
		.first_z(first_z),
		.second_x(second_x),
		.second_y(second_y),
		.second_z(second_z),
		.sphere_radius(sphere_radius),
		.done(done),
		.visible(visible),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// exact plane test: a*x + b*y + c*z + d*1.0 >= 0 for every plane
	function automatic bit inside_frustum(longint x, longint y, longint z);
		longint pa, pb, pc, pd, acc;
		bit ok;
		ok = 1'b1;
		for (int p = 0; p < PLANES_TESTED && p < fpbc_pkg::NUM_PLANE_REGS; p++) begin
			pa = $signed(plane_model[p].a);
			pb = $signed(plane_model[p].b);
			pc = $signed(plane_model[p].c);
			pd = $signed(plane_model[p].d);
			acc = pa * x + pb * y + pc * z + (pd << fpbc_pkg::ONE_SHIFT);
			if (acc < 0)
				ok = 1'b0;
		end
		return ok;
	endfunction

	// center (floored) or any of the eight corners
	function automatic bit box_seen(longint lx, longint ly, longint lz,
			longint hx, longint hy, longint hz);
		bit seen;
		seen = inside_frustum((lx + hx) >>> 1, (ly + hy) >>> 1, (lz + hz) >>> 1);
		for (int c = 0; c < 8; c++) begin
			if (inside_frustum(c[0] ? hx : lx, c[1] ? hy : ly, c[2] ? hz : lz))
				seen = 1'b1;
		end
		return seen;
	endfunction

	function automatic bit predict_visible(cull_word_t w);
		longint fx, fy, fz, sx, sy, sz, r;
		fx = w.fx;
		fy = w.fy;
		fz = w.fz;
		sx = w.sx;
		sy = w.sy;
		sz = w.sz;
		r = w.rad;
		case (w.act)
			fpbc_pkg::ACT_POINT: return inside_frustum(fx, fy, fz);
			fpbc_pkg::ACT_BOX: return box_seen(fx, fy, fz, sx, sy, sz);
			fpbc_pkg::ACT_SPHERE: return box_seen(fx - r, fy - r, fz - r,
				fx + r, fy + r, fz + r);
			default: return 1'b0;
		endcase
	endfunction

	task automatic flag_error(input string what, input int want, input int got);
		if (errors < REPORT_MAX)
			$display("tb: %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (visible_q.size() == 0) begin
					flag_error("unexpected result", -1, visible);
				end else begin
					want_vis = visible_q.pop_front();
					if (visible !== want_vis)
						flag_error("visible mismatch", want_vis, visible);
				end
			end
			if (start && !busy) begin
				visible_q.push_back(predict_visible(cur_word));
				accept_count <= accept_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic cull_word_t make_word(fpbc_pkg::action_t act, int fx, int fy, int fz,
			int sx, int sy, int sz, int rad);
		cull_word_t w;
		w.act = act;
		w.fx = fx[15:0];
		w.fy = fy[15:0];
		w.fz = fz[15:0];
		w.sx = sx[15:0];
		w.sy = sy[15:0];
		w.sz = sz[15:0];
		w.rad = rad[14:0];
		return w;
	endfunction

	function automatic logic [fpbc_pkg::CFG_W-1:0] pack_plane(int a, int b, int c, int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	function automatic logic signed [15:0] rand_coord(int span);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = int'($urandom_range(0, 2 * span)) - span;
		endcase
		return v[15:0];
	endfunction

	function automatic cull_word_t rand_word(int span);
		cull_word_t w;
		logic signed [15:0] t;
		int r;
		r = $urandom_range(0, 19);
		w.act = (r == 0) ? fpbc_pkg::ACT_NONE : fpbc_pkg::action_t'(r % 3);
		w.fx = rand_coord(span);
		w.fy = rand_coord(span);
		w.fz = rand_coord(span);
		w.sx = rand_coord(span);
		w.sy = rand_coord(span);
		w.sz = rand_coord(span);
		if ($urandom_range(0, 4) != 0) begin
			if (w.fx > w.sx) begin t = w.fx; w.fx = w.sx; w.sx = t; end
			if (w.fy > w.sy) begin t = w.fy; w.fy = w.sy; w.sy = t; end
			if (w.fz > w.sz) begin t = w.fz; w.fz = w.sz; w.sz = t; end
		end
		if ($urandom_range(0, 9) < 7)
			w.rad = 15'($urandom_range(0, span));
		else
			w.rad = 15'($urandom_range(0, 32767));
		return w;
	endfunction

	function automatic logic [15:0] extreme_field();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic send_word(input cull_word_t w);
		int gap;
		int seen;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 9);
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(16, 64);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seen = accept_count;
		cur_word <= w;
		start <= 1'b1;
		do @(negedge clk); while (accept_count == seen);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (visible_q.size() != 0)
			@(negedge clk);
		repeat (HOLD_OFF) @(negedge clk);
	endtask

	task automatic write_plane(input int idx, input logic [fpbc_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx[fpbc_pkg::CFG_IDX_W-1:0];
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < fpbc_pkg::NUM_PLANE_REGS)
			plane_model[idx] = fpbc_pkg::plane_t'(data);
	endtask

	task automatic load_planes();
		for (int i = 0; i < fpbc_pkg::NUM_PLANE_REGS; i++)
			write_plane(i, plane_set[i]);
	endtask

	// planes cleared by reset: everything visible except the unused action
	task automatic test_reset_planes();
		send_word(make_word(fpbc_pkg::ACT_POINT, 32767, -32768, 0, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_BOX, -32768, -32768, -32768,
			32767, 32767, 32767, 0));
		send_word(make_word(fpbc_pkg::ACT_SPHERE, 32767, -32768, 32767, 0, 0, 0, 32767));
		send_word(make_word(fpbc_pkg::ACT_NONE, -1, -1, -1, -1, -1, -1, 32767));
		drain_results();
	endtask

	// unit cube: -1.0 <= x,y,z <= 1.0
	task automatic test_unit_cube();
		plane_set[0] = pack_plane(16384, 0, 0, 16384);
		plane_set[1] = pack_plane(-16384, 0, 0, 16384);
		plane_set[2] = pack_plane(0, 16384, 0, 16384);
		plane_set[3] = pack_plane(0, -16384, 0, 16384);
		plane_set[4] = pack_plane(0, 0, 16384, 16384);
		plane_set[5] = pack_plane(0, 0, -16384, 16384);
		load_planes();
		send_word(make_word(fpbc_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_POINT, 256, -256, 256, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_POINT, 257, 0, 0, 0, 0, 0, 0));
		// min above max, center lands inside
		send_word(make_word(fpbc_pkg::ACT_BOX, 300, 300, 300, -300, -300, -300, 0));
		send_word(make_word(fpbc_pkg::ACT_BOX, 300, 300, 300, 600, 600, 600, 0));
		send_word(make_word(fpbc_pkg::ACT_BOX, 200, 200, 200, 1000, 1000, 1000, 0));
		send_word(make_word(fpbc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_SPHERE, 600, 0, 0, 0, 0, 0, 400));
		drain_results();
	endtask

	// indexes past the last plane must leave the planes alone
	task automatic test_ignored_index();
		write_plane(6, {$urandom, $urandom});
		write_plane(7, {$urandom, $urandom});
		send_word(make_word(fpbc_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_POINT, -257, 0, 0, 0, 0, 0, 0));
		drain_results();
	endtask

	task automatic test_extreme_planes();
		for (int i = 0; i < fpbc_pkg::NUM_PLANE_REGS; i++)
			plane_set[i] = {4{16'h7FFF}};
		load_planes();
		send_word(make_word(fpbc_pkg::ACT_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_SPHERE, -32768, -32768, -32768,
			0, 0, 0, 32767));
		drain_results();
		for (int i = 0; i < fpbc_pkg::NUM_PLANE_REGS; i++)
			plane_set[i] = {4{16'h8000}};
		load_planes();
		send_word(make_word(fpbc_pkg::ACT_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
		send_word(make_word(fpbc_pkg::ACT_BOX, -32768, -32768, -32768,
			32767, 32767, 32767, 0));
		drain_results();
	endtask

	task automatic test_random_settings();
		int span;
		int kb;
		int k;
		int d0;
		int d1;
		for (int s = 0; s < SET_COUNT; s++) begin
			case ($urandom_range(0, 4))
				0: span = 256;
				1: span = 1024;
				2: span = 4096;
				3: span = 16384;
				default: span = 32767;
			endcase
			for (int i = 0; i < fpbc_pkg::NUM_PLANE_REGS; i++) begin
				case (s)
					0: plane_set[i] = '0;
					1: plane_set[i] = '1;
					2, 9: plane_set[i] = {extreme_field(), extreme_field(),
						extreme_field(), extreme_field()};
					3: plane_set[i] = {$urandom, $urandom};
					default: plane_set[i] = '0;
				endcase
			end
			if (s >= 4 && s <= 8) begin
				// axis slabs around a random region
				kb = $urandom_range(32, 16384);
				span = 6000 * 256 / kb + 64;
				if (span > 32767)
					span = 32767;
				for (int ax = 0; ax < 3; ax++) begin
					k = kb + $urandom_range(0, kb / 4);
					d0 = int'($urandom_range(0, 12000)) - 2000;
					d1 = int'($urandom_range(0, 12000)) - 2000;
					plane_set[2 * ax] = '0;
					plane_set[2 * ax + 1] = '0;
					plane_set[2 * ax][16 * ax +: 16] = k[15:0];
					plane_set[2 * ax][63:48] = d0[15:0];
					plane_set[2 * ax + 1][16 * ax +: 16] = 16'(-k);
					plane_set[2 * ax + 1][63:48] = d1[15:0];
				end
			end
			load_planes();
			if ($urandom_range(0, 2) == 0)
				write_plane($urandom_range(6, 7), {$urandom, $urandom});
			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				if (n == ITEMS_PER_SET / 2 && s % 3 == 0)
					drain_results();
				send_word(rand_word(span));
			end
			drain_results();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cur_word = make_word(fpbc_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		burst_left = 0;
		for (int i = 0; i < fpbc_pkg::NUM_PLANE_REGS; i++)
			plane_model[i] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_planes();
		test_unit_cube();
		test_ignored_index();
		test_extreme_planes();
		test_random_settings();

		drain_results();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
